/* src/hfl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_pkg
// Shared widths, codes, cell layout and controller/datapath command types
// for the honest forest leaf-mean predictor.
// ----------------------------------------------------------------------------
package hfl_pkg;

  // Field widths
  localparam int TREE_W    = 6;
  localparam int LEAF_W    = 8;
  localparam int TT_W      = 7;
  localparam int CELL_W    = 13;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 24;
  localparam int OUT_W     = 18;

  // Divider geometry: numerator holds |d| << FRAC_BITS plus half the count
  localparam int NUM_W  = CELL_W + FRAC_BITS;
  localparam int DEN_W  = CELL_W;
  localparam int QCNT_W = $clog2(NUM_W);

  localparam logic [CELL_W-1:0] CELL_MAX = '1;
  localparam logic [TT_W-1:0]   TT_RESET = TT_W'(1);

  // Operation codes
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_PREDICT    = 1'b1;

  typedef struct packed {
    logic [CELL_W-1:0] upper_sum;
    logic [CELL_W-1:0] lower_sum;
    logic [CELL_W-1:0] leaf_count;
  } cell_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ACC_WR,
    ST_EST,
    ST_DIV_EST,
    ST_ADD,
    ST_AVG,
    ST_DIV_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic in_ready;
    logic rd_en;
    logic acc_wr;
    logic est_start;
    logic acc_add;
    logic avg_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic item_op;
    logic item_last;
    logic div_done;
    logic clr_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* src/hfl_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_in_if
// Input channel: one beat is an accumulate or a predict item.
// ----------------------------------------------------------------------------
interface hfl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [hfl_pkg::TREE_W-1:0]   tree_number;
  logic [hfl_pkg::LEAF_W-1:0]   leaf_number;
  logic                         upper_flag;
  logic                         lower_flag;
  logic                         last_tree;

  modport source (
    output valid, operation, tree_number, leaf_number, upper_flag, lower_flag,
           last_tree,
    input  ready
  );

  modport sink (
    input  valid, operation, tree_number, leaf_number, upper_flag, lower_flag,
           last_tree,
    output ready
  );
endinterface
`default_nettype wire

/* src/hfl_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_out_if
// Result channel: one beat carries one averaged prediction.
// ----------------------------------------------------------------------------
interface hfl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hfl_pkg::OUT_W-1:0]  prediction;

  modport source (
    output valid, prediction,
    input  ready
  );

  modport sink (
    input  valid, prediction,
    output ready
  );
endinterface
`default_nettype wire

/* src/hfl_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/hfl_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_div
// Restoring divider, one quotient bit per cycle, shared by the leaf
// estimate and the final average.
// ----------------------------------------------------------------------------
module hfl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [hfl_pkg::NUM_W-1:0]   num,
  input  wire logic [hfl_pkg::DEN_W-1:0]   den,
  output logic                             busy,
  output logic                             done,
  output logic      [hfl_pkg::NUM_W-1:0]   quot
);

  localparam int NW = hfl_pkg::NUM_W;
  localparam int DW = hfl_pkg::DEN_W;
  localparam int CW = hfl_pkg::QCNT_W;

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial    = {rem_r, num_r[NW-1]};
    qbit     = (trial >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      num_nxt = {num_r[NW-2:0], qbit};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire

/* src/hfl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_ctrl
// Sequencer: clearing pass, read-modify-write for accumulate beats and the
// divide/add/average sequence for predict beats.
// ----------------------------------------------------------------------------
module hfl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hfl_pkg::status_t status,
  output hfl_pkg::cmd_t         cmd
);

  hfl_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hfl_pkg::ST_CLEAR: begin
        if (status.clr_done) state_nxt = hfl_pkg::ST_IDLE;
      end
      hfl_pkg::ST_IDLE: begin
        if (status.accept) state_nxt = hfl_pkg::ST_READ;
      end
      hfl_pkg::ST_READ: begin
        state_nxt = (status.item_op == hfl_pkg::OP_PREDICT) ? hfl_pkg::ST_EST
                                                            : hfl_pkg::ST_ACC_WR;
      end
      hfl_pkg::ST_ACC_WR:  state_nxt = hfl_pkg::ST_IDLE;
      hfl_pkg::ST_EST:     state_nxt = hfl_pkg::ST_DIV_EST;
      hfl_pkg::ST_DIV_EST: begin
        if (status.div_done) state_nxt = hfl_pkg::ST_ADD;
      end
      hfl_pkg::ST_ADD: begin
        state_nxt = status.item_last ? hfl_pkg::ST_AVG : hfl_pkg::ST_IDLE;
      end
      hfl_pkg::ST_AVG:     state_nxt = hfl_pkg::ST_DIV_AVG;
      hfl_pkg::ST_DIV_AVG: begin
        if (status.div_done) state_nxt = hfl_pkg::ST_OUT;
      end
      hfl_pkg::ST_OUT: begin
        if (status.out_free) state_nxt = hfl_pkg::ST_IDLE;
      end
      default: state_nxt = hfl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      hfl_pkg::ST_CLEAR: cmd.clear     = 1'b1;
      hfl_pkg::ST_IDLE:  cmd.in_ready  = 1'b1;
      hfl_pkg::ST_READ:  cmd.rd_en     = 1'b1;
      hfl_pkg::ST_ACC_WR: cmd.acc_wr   = 1'b1;
      hfl_pkg::ST_EST:   cmd.est_start = 1'b1;
      hfl_pkg::ST_ADD:   cmd.acc_add   = 1'b1;
      hfl_pkg::ST_AVG:   cmd.avg_start = 1'b1;
      hfl_pkg::ST_OUT:   cmd.out_load  = status.out_free;
      default:           cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/hfl_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfl_dp
// Datapath: item capture, cell memory, leaf estimate, running total,
// final average and the output register.
// ----------------------------------------------------------------------------
module hfl_dp #(
  parameter int MAX_TREES       = 64,
  parameter int LEAVES_PER_TREE = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  hfl_in_if.sink                          in_chan,
  hfl_out_if.source                       out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [hfl_pkg::TT_W-1:0]   cfg_wdata,
  input  wire hfl_pkg::cmd_t              cmd,
  output hfl_pkg::status_t                status
);

  localparam int CELLS   = MAX_TREES * LEAVES_PER_TREE;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int CW      = hfl_pkg::CELL_W;
  localparam int NW      = hfl_pkg::NUM_W;
  localparam int DW      = hfl_pkg::DEN_W;
  localparam int AW      = hfl_pkg::ACC_W;
  localparam int OW      = hfl_pkg::OUT_W;
  localparam int TW      = hfl_pkg::TT_W;
  localparam int FB      = hfl_pkg::FRAC_BITS;
  localparam int EST_W   = NW + 1;
  localparam int SUM_W   = EST_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2**(AW-1) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2**(AW-1)));
  localparam logic [NW-1:0]           Q_LIM   = NW'(2**FB);

  // captured item
  logic                          op_r, up_r, lo_r, last_r;
  logic [hfl_pkg::TREE_W-1:0]    tree_r;
  logic [hfl_pkg::LEAF_W-1:0]    leaf_r;
  logic                          accept;
  logic                          item_valid;
  logic [IDX_W-1:0]              cell_idx;

  // clearing pass
  logic [IDX_W-1:0]              clr_addr_r, clr_addr_nxt;

  // cell memory
  hfl_pkg::cell_t                rd_cell, upd_cell, ram_wdata;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;

  // estimate and average operands
  logic                          d_neg, empty;
  logic [CW-1:0]                 d_mag;
  logic [NW-1:0]                 num_est, num_avg, div_num;
  logic [DW-1:0]                 den_est, div_den;
  logic [TW-1:0]                 den_tt;
  logic                          acc_neg;
  logic [AW-1:0]                 acc_mag;
  logic                          sign_r, zero_r;

  // divider
  logic                          div_start, div_busy, div_done;
  logic [NW-1:0]                 quot;

  // running total
  logic signed [AW-1:0]          acc_r, acc_nxt;
  logic signed [EST_W-1:0]       est_val;
  logic signed [SUM_W-1:0]       sum;

  // configuration and output
  logic [TW-1:0]                 tree_total_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]          out_pred_r;
  logic [NW-1:0]                 q_clamp;
  logic signed [OW-1:0]          pred;

  assign accept     = in_chan.valid && cmd.in_ready;
  assign item_valid = (32'(tree_r) < MAX_TREES) && (32'(leaf_r) < LEAVES_PER_TREE);
  assign cell_idx   = IDX_W'(tree_r) * IDX_W'(LEAVES_PER_TREE) + IDX_W'(leaf_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.operation;
      tree_r <= in_chan.tree_number;
      leaf_r <= in_chan.leaf_number;
      up_r   <= in_chan.upper_flag;
      lo_r   <= in_chan.lower_flag;
      last_r <= in_chan.last_tree;
    end
  end

  // Sweep every cell to zero after reset
  assign clr_addr_nxt = cmd.clear ? clr_addr_r + IDX_W'(1) : clr_addr_r;

  // Saturating increments of the read cell
  always_comb begin
    upd_cell.upper_sum  = rd_cell.upper_sum
                        + CW'(up_r && (rd_cell.upper_sum != hfl_pkg::CELL_MAX));
    upd_cell.lower_sum  = rd_cell.lower_sum
                        + CW'(lo_r && (rd_cell.lower_sum != hfl_pkg::CELL_MAX));
    upd_cell.leaf_count = rd_cell.leaf_count
                        + CW'(rd_cell.leaf_count != hfl_pkg::CELL_MAX);
  end

  assign ram_we    = cmd.clear || (cmd.acc_wr && item_valid);
  assign ram_waddr = cmd.clear ? clr_addr_r : cell_idx;
  assign ram_wdata = cmd.clear ? '0 : upd_cell;

  hfl_ram #(
    .WIDTH ($bits(hfl_pkg::cell_t)),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (cell_idx),
    .rdata (rd_cell)
  );

  // Leaf estimate operands: |upper - lower| << FRAC_BITS, rounded by count/2
  always_comb begin
    d_neg   = rd_cell.lower_sum > rd_cell.upper_sum;
    d_mag   = d_neg ? rd_cell.lower_sum - rd_cell.upper_sum
                    : rd_cell.upper_sum - rd_cell.lower_sum;
    empty   = (rd_cell.leaf_count == '0) || !item_valid;
    num_est = {d_mag, {FB{1'b0}}} + NW'(rd_cell.leaf_count >> 1);
    den_est = empty ? DW'(1) : rd_cell.leaf_count;
  end

  // Final average operands
  always_comb begin
    acc_neg = acc_r[AW-1];
    acc_mag = acc_neg ? AW'(0) - AW'(acc_r) : AW'(acc_r);
    den_tt  = (tree_total_r == '0) ? TW'(1) : tree_total_r;
    num_avg = NW'(acc_mag) + NW'(den_tt >> 1);
  end

  assign div_start = cmd.est_start || cmd.avg_start;
  assign div_num   = cmd.est_start ? num_est : num_avg;
  assign div_den   = cmd.est_start ? den_est : DW'(den_tt);

  always_ff @(posedge clk) begin
    if (cmd.est_start) begin
      sign_r <= d_neg;
      zero_r <= empty;
    end else if (cmd.avg_start) begin
      sign_r <= acc_neg;
    end
  end

  hfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  // Add the signed leaf estimate, saturate to the total's range
  always_comb begin
    if (zero_r) begin
      est_val = '0;
    end else if (sign_r) begin
      est_val = EST_W'(0) - $signed({1'b0, quot});
    end else begin
      est_val = $signed({1'b0, quot});
    end
    sum     = SUM_W'(acc_r) + SUM_W'(est_val);
    acc_nxt = acc_r;
    if (cmd.acc_add) begin
      if (sum > SUM_MAX) begin
        acc_nxt = AW'(SUM_MAX);
      end else if (sum < SUM_MIN) begin
        acc_nxt = AW'(SUM_MIN);
      end else begin
        acc_nxt = AW'(sum);
      end
    end else if (cmd.out_load) begin
      acc_nxt = '0;
    end
  end

  // Clamp the average to one in magnitude, reapply the sign
  always_comb begin
    q_clamp = (quot > Q_LIM) ? Q_LIM : quot;
    pred    = sign_r ? OW'(0) - OW'(q_clamp) : OW'(q_clamp);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      acc_r        <= '0;
      tree_total_r <= hfl_pkg::TT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tree_total_r <= cfg_wdata;
      end
    end
    if (cmd.out_load) begin
      out_pred_r <= pred;
    end
  end

  assign in_chan.ready       = cmd.in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.prediction = out_pred_r;

  always_comb begin
    status.accept    = accept;
    status.item_op   = op_r;
    status.item_last = last_r;
    status.div_done  = div_done;
    status.clr_done  = (clr_addr_r == IDX_W'(CELLS - 1));
    status.out_free  = !out_valid_r || out_chan.ready;
  end

  // Never overwrite a beat that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_chan.ready))
    else $error("result loaded over an untaken beat");

  // The running total starts afresh after each emitted prediction
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (acc_r == '0))
    else $error("running total not cleared after result");

  // A cell write-back always follows its read
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_wr |-> $past(cmd.rd_en))
    else $error("cell write without preceding read");

  // The shared divider is never restarted mid-division
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

/* src/honest_forest_leaf_mean_predict.sv */
// Sequence: accumulate beat ST_READ, ST_ACC_WR; predict beat ST_READ, ST_EST,
//   ST_DIV_EST, ST_ADD, then on the last tree ST_AVG, ST_DIV_AVG and ST_OUT.
// Flow: one beat at a time; the restoring divider sets the predict rate, used
//   once per tree and once more for the final average.
// Reset: synchronous, active low; a clearing pass zeroes every one of the
//   MAX_TREES*LEAVES_PER_TREE cells (16384 by default) before in_chan.ready rises.
`default_nettype none
// ----------------------------------------------------------------------------
// honest_forest_leaf_mean_predict
// Honest forest prediction: accumulate per-leaf class sums and counts, then
// average mean(upper) - mean(lower) over the trees of one observation.
// ----------------------------------------------------------------------------
module honest_forest_leaf_mean_predict #(
  parameter int MAX_TREES       = 64,
  parameter int LEAVES_PER_TREE = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  hfl_in_if.sink                          in_chan,
  hfl_out_if.source                       out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [hfl_pkg::TT_W-1:0]   cfg_wdata
);

  // Controller and datapath talk only through these two bundles
  hfl_pkg::cmd_t    cmd;
  hfl_pkg::status_t status;

  // Sequence each beat: clear sweep, cell read-modify-write, divide, add,
  // average and hand over to the output register
  hfl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // Hold the cell memory, the shared divider, the running total and the
  // output register; the output register lets the next beat in while a
  // result still waits
  hfl_dp #(
    .MAX_TREES       (MAX_TREES),
    .LEAVES_PER_TREE (LEAVES_PER_TREE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the honest forest leaf-mean predictor. A table of
// directed beats, a run that pins the running sum at both rails and random
// phases over several tree totals drive the input channel; every prediction
// beat is checked against a typed-in value or a behavioural model of the
// per-leaf tallies and the running tree sum.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TREE_W    = hfl_pkg::TREE_W;
  localparam int LEAF_W    = hfl_pkg::LEAF_W;
  localparam int CELL_W    = hfl_pkg::CELL_W;
  localparam int TT_W      = hfl_pkg::TT_W;
  localparam int OUT_W     = hfl_pkg::OUT_W;
  localparam int ACC_W     = hfl_pkg::ACC_W;
  localparam int FRAC_BITS = hfl_pkg::FRAC_BITS;

  localparam int MAX_TREES  = 64;
  localparam int LEAVES     = 256;
  localparam int NUM_CELLS  = MAX_TREES * LEAVES;
  // Longest in-flight work: a predict beat on the last tree, with both divisions
  localparam int DRAIN      = 100;
  localparam int LONG_STALL = 3000;
  // Enough same-sign full-scale estimates to push the running sum past a rail
  localparam int RAIL_RUN   = 130;

  localparam longint SUM_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) << (ACC_W - 1));
  localparam longint Q_ONE   = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic              op;
    logic [TREE_W-1:0] tree;
    logic [LEAF_W-1:0] leaf;
    logic              up;
    logic              lo;
    logic              last;
  } beat_t;

  // One directed row: the beat, and a typed-in result where it is obvious
  typedef struct packed {
    logic              op;
    logic [TREE_W-1:0] tree;
    logic [LEAF_W-1:0] leaf;
    logic              up;
    logic              lo;
    logic              last;
    logic              typed;
    logic [OUT_W-1:0]  want;
  } dir_row_t;

  localparam int N_DIR = 21;

  // Tree total stays at its reset value of one throughout this table.
  dir_row_t dir_rows [0:N_DIR-1] = '{
    // empty leaf straight after reset contributes nothing
    '{hfl_pkg::OP_PREDICT,    6'd0,  8'd0,   1'b0, 1'b0, 1'b1, 1'b1, 18'h00000},
    // top tree, top leaf: one upper hit gives a full-scale mean
    '{hfl_pkg::OP_ACCUMULATE, 6'd63, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd63, 8'd255, 1'b0, 1'b0, 1'b1, 1'b1, 18'h10000},
    // lower hit without upper: full-scale negative
    '{hfl_pkg::OP_ACCUMULATE, 6'd0,  8'd255, 1'b0, 1'b1, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd0,  8'd255, 1'b0, 1'b0, 1'b1, 1'b1, 18'h30000},
    // last-tree flag on an accumulate beat is ignored
    '{hfl_pkg::OP_ACCUMULATE, 6'd63, 8'd0,   1'b1, 1'b1, 1'b1, 1'b0, 18'h00000},
    // class flags on a predict beat are ignored; leaf mean is zero
    '{hfl_pkg::OP_PREDICT,    6'd63, 8'd0,   1'b1, 1'b0, 1'b1, 1'b1, 18'h00000},
    '{hfl_pkg::OP_ACCUMULATE, 6'd63, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    // no last tree: no result, total carries over (+0.5)
    '{hfl_pkg::OP_PREDICT,    6'd63, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd0,  8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 18'h38000},
    // alternating bit patterns on tree and leaf, means of one third
    '{hfl_pkg::OP_ACCUMULATE, 6'd21, 8'd170, 1'b1, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_ACCUMULATE, 6'd21, 8'd170, 1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_ACCUMULATE, 6'd21, 8'd170, 1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd21, 8'd170, 1'b0, 1'b0, 1'b1, 1'b0, 18'h00000},
    '{hfl_pkg::OP_ACCUMULATE, 6'd42, 8'd85,  1'b0, 1'b1, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_ACCUMULATE, 6'd42, 8'd85,  1'b1, 1'b1, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_ACCUMULATE, 6'd42, 8'd85,  1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd42, 8'd85,  1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd21, 8'd170, 1'b0, 1'b0, 1'b1, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd63, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 18'h00000},
    '{hfl_pkg::OP_PREDICT,    6'd42, 8'd85,  1'b0, 1'b0, 1'b1, 1'b0, 18'h00000}
  };

  // Random phases: tree total and number of input beats
  localparam int N_PHASES = 6;
  int phase_trees [0:N_PHASES-1] = '{3, 0, 64, 2, 127, 5};
  int phase_beats [0:N_PHASES-1] = '{170, 80, 140, 170, 120, 100};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [TT_W-1:0] cfg_wdata;

  hfl_in_if  in_chan ();
  hfl_out_if out_chan ();

  honest_forest_leaf_mean_predict uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model state: per-leaf tallies, running tree sum and the tree total
  // --------------------------------------------------------------------------
  bit [CELL_W-1:0] up_tally  [NUM_CELLS];
  bit [CELL_W-1:0] lo_tally  [NUM_CELLS];
  bit [CELL_W-1:0] obs_tally [NUM_CELLS];
  longint          tree_sum  = 0;
  int              avg_trees = 1;

  logic [OUT_W-1:0] pending_predictions [$];

  int error_count   = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_req      = 0;
  int directed_beats, saturation_beats;

  logic [OUT_W-1:0] mon_want;

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] mismatch, %s: got %0d (0x%05h), want %0d (0x%05h)", $time,
               what, $signed(got), got, $signed(want), want);
  endtask

  // Round to nearest, ties away from zero; den is positive
  function automatic longint round_half_away(input longint num, input longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // Honest estimate of one leaf: mean(upper) - mean(lower) in Q1.16
  function automatic longint leaf_mean_diff(input int cidx);
    longint d;
    if (obs_tally[cidx] == 0)
      return 0;
    d = longint'(up_tally[cidx]) - longint'(lo_tally[cidx]);
    return round_half_away(d * Q_ONE, longint'(obs_tally[cidx]));
  endfunction

  // Advance the model by one accepted beat. Tree and leaf widths match the
  // block's limits, so every index is in range here.
  task automatic apply_beat_to_forest(input beat_t b, output bit has_res,
                                      output logic [OUT_W-1:0] res);
    int     cidx;
    longint t;
    longint avg;
    has_res = 1'b0;
    res     = '0;
    cidx    = int'(b.tree) * LEAVES + int'(b.leaf);
    if (b.op == hfl_pkg::OP_ACCUMULATE) begin
      if (b.up && up_tally[cidx] != hfl_pkg::CELL_MAX)
        up_tally[cidx]++;
      if (b.lo && lo_tally[cidx] != hfl_pkg::CELL_MAX)
        lo_tally[cidx]++;
      if (obs_tally[cidx] != hfl_pkg::CELL_MAX)
        obs_tally[cidx]++;
      return;
    end
    t = tree_sum + leaf_mean_diff(cidx);
    if (t > SUM_MAX)
      t = SUM_MAX;
    if (t < SUM_MIN)
      t = SUM_MIN;
    tree_sum = t;
    if (!b.last)
      return;
    // A tree total of zero averages over one tree
    avg = round_half_away(tree_sum, (avg_trees == 0) ? 1 : avg_trees);
    if (avg > Q_ONE)
      avg = Q_ONE;
    if (avg < -Q_ONE)
      avg = -Q_ONE;
    res      = avg[OUT_W-1:0];
    has_res  = 1'b1;
    tree_sum = 0;
  endtask

  // --------------------------------------------------------------------------
  // Input side: drive at the falling edge, take the handshake at the rising
  // --------------------------------------------------------------------------
  task automatic drive_beat(input beat_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= b.op;
    in_chan.tree_number <= b.tree;
    in_chan.leaf_number <= b.leaf;
    in_chan.upper_flag  <= b.up;
    in_chan.lower_flag  <= b.lo;
    in_chan.last_tree   <= b.last;
    @(posedge clk);
    while (!in_chan.ready)
      @(posedge clk);
    beats_sent++;
  endtask

  // Send one beat and queue its result; a typed value overrides the model
  task automatic send_beat(input beat_t b, input bit typed, input logic [OUT_W-1:0] want);
    bit               has_res;
    logic [OUT_W-1:0] res;
    drive_beat(b);
    apply_beat_to_forest(b, has_res, res);
    if (has_res)
      pending_predictions.push_back(typed ? want : res);
  endtask

  // Drop valid, let every expected beat arrive, then let trailing work finish
  task automatic settle_block();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_predictions.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_tree_total(input int v);
    settle_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= TT_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    avg_trees = v;
  endtask

  // Mostly a small pool of cells so predictions land on populated leaves
  function automatic beat_t pick_beat(input logic op, input logic last);
    beat_t b;
    b.op = op;
    if ($urandom_range(0, 4) != 0) begin
      b.tree = TREE_W'($urandom_range(0, 7));
      b.leaf = LEAF_W'($urandom_range(0, 3));
    end else begin
      b.tree = TREE_W'($urandom_range(0, MAX_TREES - 1));
      b.leaf = LEAF_W'($urandom_range(0, LEAVES - 1));
    end
    b.up   = 1'($urandom_range(0, 1));
    b.lo   = 1'($urandom_range(0, 1));
    b.last = last;
    return b;
  endfunction

  task automatic run_random_phase(input int trees, input int n_beats);
    int    start;
    int    pick;
    int    len;
    beat_t b;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // burst of honest observations
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_beat(pick_beat(hfl_pkg::OP_ACCUMULATE, 1'($urandom_range(0, 1))),
                    1'b0, '0);
      end else if (pick < 88) begin
        // one observation across the trees, now and then cut short
        len = (trees == 0) ? 1 : trees;
        if ($urandom_range(0, 6) == 0)
          len = $urandom_range(1, len);
        for (int i = 0; i < len; i++)
          send_beat(pick_beat(hfl_pkg::OP_PREDICT, 1'(i == len - 1)), 1'b0, '0);
      end else begin
        // noise: any field, any operation
        b      = pick_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        b.tree = TREE_W'($urandom_range(0, MAX_TREES - 1));
        b.leaf = LEAF_W'($urandom_range(0, LEAVES - 1));
        send_beat(b, 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int hold_ack;
    hold_left      = 0;
    hold_ack       = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_predictions.size() == 0) begin
        report_mismatch("prediction beat with nothing expected", out_chan.prediction, '0);
      end else begin
        mon_want = pending_predictions.pop_front();
        if (out_chan.prediction !== mon_want)
          report_mismatch("prediction", out_chan.prediction, mon_want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    beat_t b;
    int    start;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.operation   = hfl_pkg::OP_ACCUMULATE;
    in_chan.tree_number = '0;
    in_chan.leaf_number = '0;
    in_chan.upper_flag  = 1'b0;
    in_chan.lower_flag  = 1'b0;
    in_chan.last_tree   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles a little, receiver a lot; the clearing pass is covered
    // by waiting on ready
    tx_idle_pct = 8;
    rx_idle_pct = 49;

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      b.op   = dir_rows[i].op;
      b.tree = dir_rows[i].tree;
      b.leaf = dir_rows[i].leaf;
      b.up   = dir_rows[i].up;
      b.lo   = dir_rows[i].lo;
      b.last = dir_rows[i].last;
      send_beat(b, dir_rows[i].typed, dir_rows[i].want);
    end
    directed_beats = beats_sent;

    // Pin the running sum at the top rail with a full-scale positive leaf,
    // step back in with one negative tree, then repeat at the bottom rail
    start = beats_sent;
    b = '{hfl_pkg::OP_ACCUMULATE, TREE_W'(12), LEAF_W'(3), 1'b1, 1'b0, 1'b0};
    send_beat(b, 1'b0, '0);
    b = '{hfl_pkg::OP_PREDICT, TREE_W'(12), LEAF_W'(3), 1'b0, 1'b0, 1'b0};
    for (int i = 0; i < RAIL_RUN; i++)
      send_beat(b, 1'b0, '0);
    b = '{hfl_pkg::OP_PREDICT, TREE_W'(0), LEAF_W'(255), 1'b0, 1'b0, 1'b1};
    send_beat(b, 1'b0, '0);
    b.last = 1'b0;
    for (int i = 0; i < RAIL_RUN; i++)
      send_beat(b, 1'b0, '0);
    b = '{hfl_pkg::OP_PREDICT, TREE_W'(12), LEAF_W'(3), 1'b0, 1'b0, 1'b1};
    send_beat(b, 1'b0, '0);
    saturation_beats = beats_sent - start;

    // Random phases over several tree totals; idling swapped from the third, then off
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 2) begin
        tx_idle_pct = 49;
        rx_idle_pct = 8;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_tree_total(phase_trees[p]);
      // hold the result side off while beats keep coming
      if (p == 1)
        hold_req++;
      run_random_phase(phase_trees[p], phase_beats[p]);
    end

    settle_block();
    if (pending_predictions.size() != 0)
      report_mismatch("expected predictions never arrived", '0, pending_predictions[0]);

    $display("Run covered %0d beats: %0d directed, %0d at the sum rails, %0d random; %0d results.",
             beats_sent, directed_beats, saturation_beats,
             beats_sent - directed_beats - saturation_beats, results_seen);
    $display("Tree totals 1, 3, 0, 64, 2, 127 and 5, one long result stall, %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, clearing pass included
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
src/hfl_pkg.sv
src/hfl_in_if.sv
src/hfl_out_if.sv
src/hfl_ram.sv
src/hfl_div.sv
src/hfl_ctrl.sv
src/hfl_dp.sv
src/honest_forest_leaf_mean_predict.sv
tb/tb_top.sv
